@@ sv/espd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_pkg: shared types and constants of the encoder speed PID drive
// Item codes, register indexes, field widths, gain and result bundles.
// ----------------------------------------------------------------------------
package espd_pkg;

	localparam int TGT_W   = 24;
	localparam int GAIN_W  = 16;
	localparam int DUTY_W  = 16;
	localparam int SPD_W   = 16;
	localparam int POS_W   = 32;
	localparam int ERR_W   = 32;
	localparam int INTEG_W = 40;
	localparam int IDX_W   = 2;

	typedef enum logic {
		OP_EDGE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP  = 2'd0,
		REG_INTEG = 2'd1,
		REG_DERIV = 2'd2,
		REG_LIMIT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop;
		logic signed [GAIN_W-1:0] integ;
		logic signed [GAIN_W-1:0] deriv;
		logic        [DUTY_W-1:0] limit;
	} gains_t;

	typedef struct packed {
		logic                    direction;
		logic       [DUTY_W-1:0] duty;
		logic signed [SPD_W-1:0] speed;
	} result_t;

endpackage

@@ sv/encoder_speed_pid_drive_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_speed_pid_drive_core: encoder speed PID drive
// Counts encoder edges; on each sample tick measures speed and runs a
// feed-forward PID step, giving direction, duty and measured speed.
//
//   channel | signals                                   | moves
//   in      | in_valid, in_ready, op, dir_level,        | edge or tick
//           | speed_setpoint                            |
//   out     | out_valid, out_ready, direction, duty,    | one result per tick
//           | speed_measured                            |
//   cfg     | cfg_we, cfg_index, cfg_data               | register write
//
// One item transfers per cycle while in_ready is high. An edge completes at
// its transfer; a tick's result goes through stages s1 to s4 to the queue.
// in_ready drops only while RESULT_DEPTH ticks are in flight or queued.
// Reset clears count, error history, integral, gains to their defaults.
// A stalled output fills the queue; edges and ticks keep transferring until
// the queue's credit runs out.
// ----------------------------------------------------------------------------
module encoder_speed_pid_drive_core #(
	parameter int RESULT_DEPTH = 8
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 op,
	input  logic                                 dir_level,
	input  logic signed [espd_pkg::TGT_W-1:0]    speed_setpoint,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic                                 direction,
	output logic        [espd_pkg::DUTY_W-1:0]   duty,
	output logic signed [espd_pkg::SPD_W-1:0]    speed_measured,
	input  logic                                 cfg_we,
	input  logic        [espd_pkg::IDX_W-1:0]    cfg_index,
	input  logic        [espd_pkg::GAIN_W-1:0]   cfg_data
);

	localparam int CW = $clog2(RESULT_DEPTH + 1);

	espd_pkg::gains_t gains_q;
	logic [CW-1:0] outst_q;
	logic in_fire, out_fire, tick_fire;
	logic res_valid;
	espd_pkg::result_t res, out_res;

	assign in_ready  = (outst_q != CW'(RESULT_DEPTH));
	assign in_fire   = in_valid && in_ready;
	assign out_fire  = out_valid && out_ready;
	assign tick_fire = in_fire && (op == espd_pkg::OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q.prop  <= 16'sd256;
			gains_q.integ <= '0;
			gains_q.deriv <= '0;
			gains_q.limit <= 16'd52429;
			outst_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (espd_pkg::reg_idx_t'(cfg_index))
					espd_pkg::REG_PROP:  gains_q.prop  <= cfg_data;
					espd_pkg::REG_INTEG: gains_q.integ <= cfg_data;
					espd_pkg::REG_DERIV: gains_q.deriv <= cfg_data;
					espd_pkg::REG_LIMIT: gains_q.limit <= cfg_data;
				endcase
			end
			if (tick_fire && !out_fire) begin
				outst_q <= outst_q + CW'(1);
			end else if (out_fire && !tick_fire) begin
				outst_q <= outst_q - CW'(1);
			end
		end
	end

	espd_pid u_pid (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_fire        (in_fire),
		.op             (op),
		.dir_level      (dir_level),
		.speed_setpoint (speed_setpoint),
		.gains          (gains_q),
		.res_valid      (res_valid),
		.res            (res)
	);

	espd_rq #(
		.DEPTH (RESULT_DEPTH)
	) u_rq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (res_valid),
		.wr_data  (res),
		.rd_en    (out_fire),
		.rd_valid (out_valid),
		.rd_data  (out_res)
	);

	assign direction      = out_res.direction;
	assign duty           = out_res.duty;
	assign speed_measured = out_res.speed;

	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		outst_q <= CW'(RESULT_DEPTH))
		else $error("outstanding ticks exceed queue depth");

	a_out_has_credit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outst_q != '0))
		else $error("result without an outstanding tick");

	a_edge_no_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (op == espd_pkg::OP_EDGE) && !out_fire) |=> $stable(outst_q))
		else $error("edge changed outstanding count");

endmodule

@@ sv/espd_pid.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_pid: position count and four-stage PID datapath
// Edges step the count at transfer; ticks run speed, error, integral,
// products, sum and clamp through stages s1 to s4, one item per cycle.
// ----------------------------------------------------------------------------
module espd_pid (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_fire,
	input  logic                              op,
	input  logic                              dir_level,
	input  logic signed [espd_pkg::TGT_W-1:0] speed_setpoint,
	input  espd_pkg::gains_t                  gains,
	output logic                              res_valid,
	output espd_pkg::result_t                 res
);

	logic [31:0] pos_q;
	logic [31:0] last_q;
	logic signed [31:0] prev_q;
	logic signed [39:0] integ_q;

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic [31:0] delta_s1;
	logic signed [23:0] tgt_s1, tgt_s2, tgt_s3;
	logic signed [15:0] spd_s2, spd_s3, spd_s4;
	logic signed [32:0] dif_s2;
	logic signed [47:0] pp_s3;
	logic signed [55:0] ip_s3;
	logic signed [48:0] dp_s3;
	logic signed [49:0] drv_s4;

	logic signed [15:0] spd_c;
	logic signed [32:0] err_w;
	logic signed [31:0] err_c;
	logic signed [32:0] psum;
	logic signed [31:0] half;
	logic signed [40:0] isum;
	logic signed [39:0] integ_c;

	logic tick_fire;
	assign tick_fire = in_fire && (op == espd_pkg::OP_TICK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			last_q  <= '0;
			prev_q  <= '0;
			integ_q <= '0;
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
		end else begin
			if (in_fire && (op == espd_pkg::OP_EDGE)) begin
				pos_q <= dir_level ? pos_q + 32'd1 : pos_q - 32'd1;
			end
			if (tick_fire) begin
				last_q <= pos_q;
			end
			if (vld_s1) begin
				prev_q  <= err_c;
				integ_q <= integ_c;
			end
			vld_s1 <= tick_fire;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// stage 1: speed, error, integral
	always_comb begin
		if (&delta_s1[31:15] || ~|delta_s1[31:15]) begin
			spd_c = delta_s1[15:0];
		end else begin
			spd_c = delta_s1[31] ? 16'sh8000 : 16'sh7FFF;
		end
		err_w = {{9{tgt_s1[23]}}, tgt_s1} - {spd_c[15], spd_c, 16'h0000};
		if (err_w[32] != err_w[31]) begin
			err_c = err_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end else begin
			err_c = err_w[31:0];
		end
		psum = {prev_q[31], prev_q} + {err_c[31], err_c};
		half = psum[32:1];
		isum = {integ_q[39], integ_q} + {{9{half[31]}}, half};
		if (isum[40] != isum[39]) begin
			integ_c = isum[40] ? {1'b1, 39'h0} : {1'b0, {39{1'b1}}};
		end else begin
			integ_c = isum[39:0];
		end
	end

	// stage 2: products; prev_q and integ_q hold this tick's error and integral
	logic signed [15:0] prop_w, integ_w, deriv_w;
	logic signed [47:0] pp;
	logic signed [55:0] ip;
	logic signed [48:0] dp;

	assign prop_w  = gains.prop;
	assign integ_w = gains.integ;
	assign deriv_w = gains.deriv;
	assign pp = prop_w * prev_q;
	assign ip = integ_w * integ_q;
	assign dp = deriv_w * dif_s2;

	// stage 3: sum with target folded in before the floor shift
	logic signed [57:0] sum;
	assign sum = {{10{pp_s3[47]}}, pp_s3} + {{2{ip_s3[55]}}, ip_s3}
		+ {{9{dp_s3[48]}}, dp_s3} + {{26{tgt_s3[23]}}, tgt_s3, 8'h00};

	always_ff @(posedge clk) begin
		delta_s1 <= pos_q - last_q;
		tgt_s1   <= speed_setpoint;
		tgt_s2   <= tgt_s1;
		spd_s2   <= spd_c;
		dif_s2   <= {err_c[31], err_c} - {prev_q[31], prev_q};
		pp_s3    <= pp;
		ip_s3    <= ip;
		dp_s3    <= dp;
		tgt_s3   <= tgt_s2;
		spd_s3   <= spd_s2;
		drv_s4   <= sum[57:8];
		spd_s4   <= spd_s3;
	end

	// stage 4: clamp and split into direction and magnitude
	logic signed [49:0] lim_x;
	logic signed [49:0] lim_n;
	logic signed [49:0] drv_n;

	assign lim_x = {34'h0, gains.limit};
	assign lim_n = -lim_x;
	assign drv_n = -drv_s4;

	always_comb begin
		res.speed = spd_s4;
		priority if (drv_s4 > lim_x) begin
			res.direction = (gains.limit != '0);
			res.duty      = gains.limit;
		end else if (drv_s4 < lim_n) begin
			res.direction = 1'b0;
			res.duty      = gains.limit;
		end else begin
			res.direction = (drv_s4 > 50'sd0);
			res.duty      = drv_s4[49] ? drv_n[15:0] : drv_s4[15:0];
		end
	end

	assign res_valid = vld_s4;

	a_duty_in_limit: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.duty <= gains.limit))
		else $error("duty beyond limit");

	a_dir_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.direction) |-> (res.duty != '0))
		else $error("positive direction with zero duty");

endmodule

@@ sv/espd_rq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// espd_rq: result queue
// Circular buffer of results between the datapath and the output channel.
// ----------------------------------------------------------------------------
module espd_rq #(
	parameter int DEPTH = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  espd_pkg::result_t wr_data,
	input  logic              rd_en,
	output logic              rd_valid,
	output espd_pkg::result_t rd_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	espd_pkg::result_t mem [DEPTH];
	logic [PW-1:0] wp_q;
	logic [PW-1:0] rp_q;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			end
			if (rd_en) begin
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wp_q] <= wr_data;
		end
	end

	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem[rp_q];

endmodule

@@ tb/tb_encoder_speed_pid_drive_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_encoder_speed_pid_drive_core: encoder speed PID drive testbench
// Drives encoder edges and sample ticks through the input channel and checks
// every tick result against a cycle-free model of the count, error history,
// saturating integral and clamped PID drive. Runs several gain settings,
// extreme ones included, under no idling, sender gaps, receiver stalls and a
// long output hold that backs the block up into its input.
// ----------------------------------------------------------------------------
module tb_encoder_speed_pid_drive_core;

	localparam int     WATCHDOG_LIMIT = 5000;
	localparam int     DRAIN_CYCLES   = 12;
	localparam int     HOLD_CYCLES    = 400;
	localparam int     PHASE_ITEMS    = 120;
	localparam int     MAX_PRINTS     = 40;
	localparam longint ERR_HI   = 64'sd2147483647;
	localparam longint ERR_LO   = -64'sd2147483648;
	localparam longint INTEG_HI = 64'sd549755813887;
	localparam longint INTEG_LO = -64'sd549755813888;
	localparam longint SPD_HI   = 64'sd32767;
	localparam longint SPD_LO   = -64'sd32768;

	typedef struct packed {
		espd_pkg::op_t                     op;
		logic                              dir_level;
		logic signed [espd_pkg::TGT_W-1:0] target;
	} enc_item_t;

	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               in_valid;
	logic                               in_ready;
	logic                               op;
	logic                               dir_level;
	logic signed [espd_pkg::TGT_W-1:0]  speed_setpoint;
	logic                               out_valid;
	logic                               out_ready;
	logic                               direction;
	logic        [espd_pkg::DUTY_W-1:0] duty;
	logic signed [espd_pkg::SPD_W-1:0]  speed_measured;
	logic                               cfg_we;
	espd_pkg::reg_idx_t                 cfg_index;
	logic        [espd_pkg::GAIN_W-1:0] cfg_data;

	enc_item_t         items_to_send[$];
	espd_pkg::result_t drive_expected[$];

	logic        [espd_pkg::POS_W-1:0]  model_count      = '0;
	logic        [espd_pkg::POS_W-1:0]  model_count_tick = '0;
	longint                             model_prev_err   = 0;
	longint                             model_integ      = 0;
	logic signed [espd_pkg::GAIN_W-1:0] gain_prop        = 16'sd256;
	logic signed [espd_pkg::GAIN_W-1:0] gain_integ       = '0;
	logic signed [espd_pkg::GAIN_W-1:0] gain_deriv       = '0;
	logic        [espd_pkg::DUTY_W-1:0] limit_duty       = 16'd52429;

	int  send_idle_pct  = 0;
	int  recv_stall_pct = 0;
	int  hold_left      = 0;
	int  quiet_cycles   = 0;
	int  mismatches     = 0;
	bit  in_took        = 1'b0;

	encoder_speed_pid_drive_core i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.op             (op),
		.dir_level      (dir_level),
		.speed_setpoint (speed_setpoint),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.direction      (direction),
		.duty           (duty),
		.speed_measured (speed_measured),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic longint sat(input longint v, input longint lo, input longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function automatic espd_pkg::result_t tick_drive(
		input logic signed [espd_pkg::TGT_W-1:0] target);
		logic [espd_pkg::POS_W-1:0] delta;
		longint                     spd;
		longint                     tgt;
		longint                     err;
		longint                     sum;
		longint                     drv;
		longint                     lim;
		longint                     mag;
		espd_pkg::result_t          r;
		delta            = model_count - model_count_tick;
		model_count_tick = model_count;
		spd = sat(longint'($signed(delta)), SPD_LO, SPD_HI);
		tgt = longint'(target);
		err = sat(tgt - spd * 64'sd65536, ERR_LO, ERR_HI);
		model_integ = sat(model_integ + ((model_prev_err + err) >>> 1), INTEG_LO, INTEG_HI);
		sum = longint'(gain_prop) * err + longint'(gain_integ) * model_integ
			+ longint'(gain_deriv) * (err - model_prev_err);
		model_prev_err = err;
		lim = longint'(limit_duty);
		drv = sat(tgt + (sum >>> 8), -lim, lim);
		if (drv > 0) begin
			r.direction = 1'b1;
			mag         = drv;
		end else begin
			r.direction = 1'b0;
			mag         = -drv;
		end
		r.duty  = mag[espd_pkg::DUTY_W-1:0];
		r.speed = spd[espd_pkg::SPD_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < MAX_PRINTS)
			$display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $time);
		mismatches++;
	endtask

	// capture transfers, predict ticks, check results
	always @(posedge clk) begin
		espd_pkg::result_t want;
		if (arst_n) begin
			in_took = in_valid && in_ready;
			if (in_took) begin
				if (op == espd_pkg::OP_EDGE)
					model_count = dir_level ? model_count + 1'b1 : model_count - 1'b1;
				else
					drive_expected.push_back(tick_drive(speed_setpoint));
			end
			if (out_valid && out_ready) begin
				if (drive_expected.size() == 0) begin
					report_mismatch("unexpected result, duty", duty, 0);
				end else begin
					want = drive_expected.pop_front();
					if (direction !== want.direction)
						report_mismatch("direction", direction, want.direction);
					if (duty !== want.duty)
						report_mismatch("duty", duty, want.duty);
					if (speed_measured !== want.speed)
						report_mismatch("speed_measured", speed_measured, want.speed);
				end
			end
			if (in_took || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	// offer items and drive out_ready on the falling edge
	always @(negedge clk) begin
		enc_item_t nxt;
		if (arst_n) begin
			if (in_valid && !in_took) begin
				// hold until transfer
			end else if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = items_to_send.pop_front();
				in_valid       <= 1'b1;
				op             <= nxt.op;
				dir_level      <= nxt.dir_level;
				speed_setpoint <= nxt.target;
			end else begin
				in_valid <= 1'b0;
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(negedge clk) begin
		if (hold_left > 0)
			hold_left = hold_left - 1;
	end

	task automatic write_reg(input espd_pkg::reg_idx_t idx,
		input logic [espd_pkg::GAIN_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			espd_pkg::REG_PROP:  gain_prop  = val;
			espd_pkg::REG_INTEG: gain_integ = val;
			espd_pkg::REG_DERIV: gain_deriv = val;
			espd_pkg::REG_LIMIT: limit_duty = val;
		endcase
	endtask

	task automatic set_gains(input int p, input int i, input int d, input int lim);
		write_reg(espd_pkg::REG_PROP, p[espd_pkg::GAIN_W-1:0]);
		write_reg(espd_pkg::REG_INTEG, i[espd_pkg::GAIN_W-1:0]);
		write_reg(espd_pkg::REG_DERIV, d[espd_pkg::GAIN_W-1:0]);
		write_reg(espd_pkg::REG_LIMIT, lim[espd_pkg::DUTY_W-1:0]);
	endtask

	task automatic wait_drained();
		while (items_to_send.size() != 0 || in_valid || drive_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic push_item(input espd_pkg::op_t o, input logic d,
		input logic signed [espd_pkg::TGT_W-1:0] t);
		enc_item_t it;
		it.op        = o;
		it.dir_level = d;
		it.target    = t;
		items_to_send.push_back(it);
	endtask

	function automatic logic signed [espd_pkg::TGT_W-1:0] rand_target();
		int v;
		v = int'($urandom_range(262143)) - 131072;
		case ($urandom_range(9))
			0: return {1'b0, {(espd_pkg::TGT_W-1){1'b1}}};
			1: return {1'b1, {(espd_pkg::TGT_W-1){1'b0}}};
			2: return '0;
			3, 4, 5: return v[espd_pkg::TGT_W-1:0];
			default: return espd_pkg::TGT_W'($urandom());
		endcase
	endfunction

	task automatic push_edges(input int n, input logic up);
		repeat (n) push_item(espd_pkg::OP_EDGE, up, espd_pkg::TGT_W'($urandom()));
	endtask

	// a run of edges, mostly one way, closed by a tick; sometimes noise
	task automatic push_sequence();
		int   n;
		logic up;
		if ($urandom_range(99) < 15) begin
			push_item(espd_pkg::op_t'($urandom_range(1)), 1'($urandom()),
				espd_pkg::TGT_W'($urandom()));
		end else begin
			case ($urandom_range(9))
				0: n = 0;
				8: n = $urandom_range(40, 7);
				9: n = $urandom_range(150, 41);
				default: n = $urandom_range(6, 1);
			endcase
			up = 1'($urandom());
			repeat (n) begin
				if ($urandom_range(99) < 85)
					push_item(espd_pkg::OP_EDGE, up, espd_pkg::TGT_W'($urandom()));
				else
					push_item(espd_pkg::OP_EDGE, ~up, espd_pkg::TGT_W'($urandom()));
			end
			push_item(espd_pkg::OP_TICK, 1'($urandom()), rand_target());
		end
	endtask

	task automatic fill_random(input int n);
		int stop_at;
		stop_at = items_to_send.size() + n;
		while (items_to_send.size() < stop_at)
			push_sequence();
	endtask

	task automatic run_random_phase(input int s_idle, input int r_stall, input int n);
		send_idle_pct  = s_idle;
		recv_stall_pct = r_stall;
		fill_random(n);
		wait_drained();
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		op             = espd_pkg::OP_EDGE;
		dir_level      = 1'b0;
		speed_setpoint = '0;
		out_ready      = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = espd_pkg::REG_PROP;
		cfg_data       = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: zero drive, clamps, ignored fields, field extremes
		push_item(espd_pkg::OP_TICK, 1'b0, 24'sd0);
		push_item(espd_pkg::OP_EDGE, 1'b1, 24'sh7FFFFF);
		push_item(espd_pkg::OP_EDGE, 1'b1, 24'sh800000);
		push_item(espd_pkg::OP_EDGE, 1'b0, 24'sh123456);
		push_item(espd_pkg::OP_TICK, 1'b0, 24'sd0);
		push_item(espd_pkg::OP_TICK, 1'b1, 24'sh7FFFFF);
		push_item(espd_pkg::OP_TICK, 1'b0, 24'sh800000);
		push_item(espd_pkg::OP_TICK, 1'b0, 24'sd32768);
		push_item(espd_pkg::OP_TICK, 1'b1, 24'sd1000);
		push_item(espd_pkg::OP_TICK, 1'b0, -24'sd1000);
		push_edges(3, 1'b0);
		push_item(espd_pkg::OP_TICK, 1'b1, -24'sd196608);
		push_item(espd_pkg::OP_EDGE, 1'b1, 24'sh555555);
		push_item(espd_pkg::OP_TICK, 1'b1, 24'sd5);
		push_item(espd_pkg::OP_TICK, 1'b0, 24'shFFFFFF);
		wait_drained();

		// extreme gains, fast runs both ways
		set_gains(32767, -32768, 32767, 65535);
		push_edges(60, 1'b1);
		push_item(espd_pkg::OP_TICK, 1'b0, 24'sh800000);
		push_edges(70, 1'b0);
		push_item(espd_pkg::OP_TICK, 1'b1, 24'sh7FFFFF);
		push_item(espd_pkg::OP_TICK, 1'b0, 24'sd0);
		run_random_phase(0, 0, PHASE_ITEMS);

		set_gains(-32768, 32767, -32768, 0);
		run_random_phase(86, 0, PHASE_ITEMS);

		set_gains(int'($urandom_range(1023)) - 512, int'($urandom_range(255)) - 128,
			int'($urandom_range(1023)) - 512, 52429);
		run_random_phase(0, 86, PHASE_ITEMS);

		// output held off while ticks keep coming, then a drain and a random phase
		set_gains(int'(16'($urandom())), int'(16'($urandom())), int'(16'($urandom())),
			int'(16'($urandom())));
		send_idle_pct  = 22;
		recv_stall_pct = 22;
		repeat (30) begin
			if ($urandom_range(1))
				push_item(espd_pkg::OP_EDGE, 1'($urandom()), espd_pkg::TGT_W'($urandom()));
			push_item(espd_pkg::OP_TICK, 1'($urandom()), rand_target());
		end
		fill_random(PHASE_ITEMS / 2);
		@(posedge clk);
		hold_left = HOLD_CYCLES;
		wait_drained();
		run_random_phase(22, 22, PHASE_ITEMS / 2);

		set_gains(256, 16, 64, 52429);
		run_random_phase(0, 0, PHASE_ITEMS);

		if (drive_expected.size() != 0)
			report_mismatch("results left over", 0, drive_expected.size());
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

@@ files.f @@
sv/espd_pkg.sv
sv/espd_pid.sv
sv/espd_rq.sv
sv/encoder_speed_pid_drive_core.sv
tb/tb_encoder_speed_pid_drive_core.sv
